/* hdl/gsbi_pkg.sv */
// Shared types and codes for the grid segment binning index.
// Used by gsbi_store and grid_segment_binning_index; depends on nothing else.
package gsbi_pkg;

    // Item opcodes.
    localparam logic [1:0] OP_ADD_WALL   = 2'd0;
    localparam logic [1:0] OP_ADD_MODEL  = 2'd1;
    localparam logic [1:0] OP_READ_HEAD  = 2'd2;
    localparam logic [1:0] OP_READ_POOL  = 2'd3;

    // Store request kinds.
    localparam logic [1:0] KIND_PUSH = 2'd0;
    localparam logic [1:0] KIND_HEAD = 2'd1;
    localparam logic [1:0] KIND_POOL = 2'd2;

    // Link value of an empty list.
    localparam logic [15:0] EMPTY_LINK = 16'hFFFF;

    typedef struct packed {
        logic        valid;
        logic [1:0]  kind;
        logic [15:0] cell_num;
        logic [15:0] slot;
        logic        typ;
        logic [15:0] obj;
    } t_store_req;

    typedef struct packed {
        logic        done;
        logic        pushed;
        logic        overflow;
        logic [15:0] link;
        logic        typ;
        logic [15:0] obj;
    } t_store_rsp;

endpackage

/* hdl/gsbi_store.sv */
// Cell head table and entry pool of the grid index, with the push and read sequencer.
// Depends on gsbi_pkg for the request and response types.
module gsbi_store #(
    parameter int CELL_COUNT = 4096,
    parameter int POOL_DEPTH = 16384,
    localparam int CW = $clog2(CELL_COUNT),
    localparam int PW = $clog2(POOL_DEPTH),
    localparam int NW = $clog2(POOL_DEPTH + 1)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  gsbi_pkg::t_store_req i_req,
    output logic                o_ready,
    output gsbi_pkg::t_store_rsp o_rsp,
    output logic [NW-1:0]       o_pool_count
);

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_BUSY  = 2'd2;

    logic [15:0] r_head_mem [CELL_COUNT];
    logic [32:0] r_pool_mem [POOL_DEPTH];

    logic [1:0]    r_state;
    logic [CW-1:0] r_clr_addr;
    logic [NW-1:0] r_count;
    logic [1:0]    r_kind;
    logic [CW-1:0] r_cell;
    logic          r_full;
    logic          r_typ;
    logic [15:0]   r_obj;
    logic [15:0]   r_head_q;
    logic [32:0]   r_pool_q;

    logic          w_accept;
    logic          w_push;
    logic          w_head_we;
    logic [CW-1:0] w_head_waddr;
    logic [15:0]   w_head_wdata;

    assign o_ready      = (r_state == S_IDLE);
    assign w_accept     = i_req.valid && o_ready;
    assign w_push       = (r_state == S_BUSY) && (r_kind == gsbi_pkg::KIND_PUSH) && !r_full;
    assign o_pool_count = r_count;

    always_comb begin
        if (r_state == S_CLEAR) begin
            w_head_we    = 1'b1;
            w_head_waddr = r_clr_addr;
            w_head_wdata = gsbi_pkg::EMPTY_LINK;
        end else begin
            w_head_we    = w_push;
            w_head_waddr = r_cell;
            w_head_wdata = 16'(r_count);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_head_we) begin
            r_head_mem[w_head_waddr] <= w_head_wdata;
        end
        r_head_q <= r_head_mem[i_req.cell_num[CW-1:0]];
    end

    // The new entry links to the old head, read in the cycle the item was taken.
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_pool_mem[r_count[PW-1:0]] <= {r_typ, r_obj, r_head_q};
        end
        r_pool_q <= r_pool_mem[i_req.slot[PW-1:0]];
    end

    // Requests are served one at a time, so a read never overlaps a write to the same entry.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
            r_count    <= '0;
        end else begin
            unique case (r_state)
                S_CLEAR: begin
                    if (r_clr_addr == CW'(CELL_COUNT - 1)) begin
                        r_state <= S_IDLE;
                    end
                    r_clr_addr <= r_clr_addr + 1'b1;
                end
                S_IDLE: begin
                    if (w_accept) begin
                        r_state <= S_BUSY;
                    end
                end
                S_BUSY: begin
                    r_state <= S_IDLE;
                    if (w_push) begin
                        r_count <= r_count + 1'b1;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_kind <= i_req.kind;
            r_cell <= i_req.cell_num[CW-1:0];
            r_full <= (r_count == NW'(POOL_DEPTH));
            r_typ  <= i_req.typ;
            r_obj  <= i_req.obj;
        end
    end

    always_comb begin
        o_rsp.done     = (r_state == S_BUSY);
        o_rsp.pushed   = w_push;
        o_rsp.overflow = (r_state == S_BUSY) && (r_kind == gsbi_pkg::KIND_PUSH) && r_full;
        if (r_kind == gsbi_pkg::KIND_POOL) begin
            o_rsp.link = r_pool_q[15:0];
            o_rsp.typ  = r_pool_q[32];
            o_rsp.obj  = r_pool_q[31:16];
        end else begin
            o_rsp.link = r_head_q;
            o_rsp.typ  = 1'b0;
            o_rsp.obj  = 16'd0;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= NW'(POOL_DEPTH))
        else $error("pool count beyond pool depth");

    a_busy_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_BUSY |=> r_state == S_IDLE)
        else $error("store busy longer than one cycle");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |=> r_count == $past(r_count) + 1'b1)
        else $error("pool count did not advance on a push");

    a_no_done_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_CLEAR |-> !o_rsp.done && !o_ready)
        else $error("request served during the clearing pass");

endmodule

/* hdl/grid_segment_binning_index.sv */
// Top level of the grid segment binning index: item sequencer and output register.
// Depends on gsbi_pkg and gsbi_store.
//
//  channel  direction  handshake          payload
//  input    in         i_valid / o_stall  i_opcode .. i_read_slot
//  output   out        o_valid / i_stall  o_cells_added .. o_read_object
//
// A read item makes at most one store request; an add-model item makes one push per cell covered.
// An add-wall item walks its columns and pushes each cell of each column's span; the walk starts at the
// wall's first column even when that lies left of the grid. Each cell is one head-table RMW.
// After reset a clearing pass over all MAP_SIZE*MAP_SIZE head-table entries runs with o_stall high.
// A finished result waits in the output register while the next item is taken.
module grid_segment_binning_index #(
    parameter int MAP_SIZE   = 64,
    parameter int POOL_DEPTH = 16384,
    parameter int FRAC_BITS  = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [1:0]         i_opcode,
    input  logic [15:0]        i_object_index,
    input  logic signed [15:0] i_x_a,
    input  logic signed [15:0] i_y_a,
    input  logic signed [15:0] i_x_b,
    input  logic signed [15:0] i_y_b,
    input  logic [14:0]        i_radius,
    input  logic               i_dynamic_flag,
    input  logic               i_description_valid,
    input  logic               i_breakable,
    input  logic [11:0]        i_read_cell,
    input  logic [13:0]        i_read_slot,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [12:0]        o_cells_added,
    output logic [14:0]        o_pool_used,
    output logic               o_to_dynamic_list,
    output logic               o_skipped_degenerate,
    output logic               o_overflow,
    output logic [15:0]        o_read_link,
    output logic               o_read_type,
    output logic [15:0]        o_read_object
);

    localparam int CELL_COUNT = MAP_SIZE * MAP_SIZE;
    localparam int MW = $clog2(MAP_SIZE);
    localparam int CW = $clog2(CELL_COUNT);
    localparam int NW = $clog2(POOL_DEPTH + 1);
    localparam int RW = 19 + FRAC_BITS;
    localparam logic signed [17:0] LastCell = 18'(MAP_SIZE - 1);

    localparam logic [3:0] T_IDLE    = 4'd0;
    localparam logic [3:0] T_SETUP   = 4'd1;
    localparam logic [3:0] T_W_INIT  = 4'd2;
    localparam logic [3:0] T_W_COL   = 4'd3;
    localparam logic [3:0] T_W_ADV   = 4'd4;
    localparam logic [3:0] T_W_SPAN  = 4'd5;
    localparam logic [3:0] T_PUSH    = 4'd6;
    localparam logic [3:0] T_WAIT    = 4'd7;
    localparam logic [3:0] T_RD_REQ  = 4'd8;
    localparam logic [3:0] T_RD_WAIT = 4'd9;
    localparam logic [3:0] T_FIN     = 4'd10;

    logic [3:0] r_state;

    // Captured item.
    logic [1:0]         r_op;
    logic [15:0]        r_obj;
    logic signed [15:0] r_xa, r_ya, r_xb, r_yb;
    logic [14:0]        r_rad;
    logic               r_route;
    logic [11:0]        r_rcell;
    logic [13:0]        r_rslot;

    // Wall walk state: major/minor axes, current column, exact minor floor and remainder.
    logic                 r_xmaj;
    logic signed [15:0]   r_m0, r_n0, r_m1;
    logic [16:0]          r_dmaj;
    logic signed [16:0]   r_dmin;
    logic signed [17:0]   r_k, r_e, r_cs, r_q, r_qs;
    logic signed [RW-1:0] r_rem, r_prod;
    logic [MW-1:0]        r_j, r_jhi;

    // Model square cursor.
    logic [MW-1:0] r_x0, r_x1, r_y1, r_cx, r_cy;

    // Result being built and the output register.
    logic [16:0] r_added;
    logic        r_ovf, r_dyn, r_degen;
    logic [15:0] r_link, r_robj;
    logic        r_rtype;
    logic        r_o_valid;
    logic [12:0] r_o_added;
    logic [14:0] r_o_used;
    logic        r_o_dyn, r_o_degen, r_o_ovf, r_o_rtype;
    logic [15:0] r_o_link, r_o_robj;

    gsbi_pkg::t_store_req w_req;
    gsbi_pkg::t_store_rsp w_rsp;
    logic                 w_st_ready;
    logic [NW-1:0]        w_pool_count;

    gsbi_store #(
        .CELL_COUNT(CELL_COUNT),
        .POOL_DEPTH(POOL_DEPTH)
    ) u_store (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (w_req),
        .o_ready      (w_st_ready),
        .o_rsp        (w_rsp),
        .o_pool_count (w_pool_count)
    );

    // Wall orientation.
    logic signed [16:0] w_dx, w_dy;
    logic [16:0]        w_adx, w_ady;
    logic               w_degen, w_xmaj, w_fwd;

    assign w_dx    = {r_xb[15], r_xb} - {r_xa[15], r_xa};
    assign w_dy    = {r_yb[15], r_yb} - {r_ya[15], r_ya};
    assign w_adx   = w_dx[16] ? 17'(-w_dx) : 17'(w_dx);
    assign w_ady   = w_dy[16] ? 17'(-w_dy) : 17'(w_dy);
    assign w_degen = (w_dx == 17'sd0) && (w_dy == 17'sd0);
    assign w_xmaj  = (w_adx >= w_ady);
    assign w_fwd   = w_xmaj ? !w_dx[16] : !w_dy[16];

    // Walk start values.
    logic signed [15:0]   w_m0_sh, w_m1_sh, w_n0_sh;
    logic signed [17:0]   w_m0_x, w_m1_x, w_m1_c;
    logic [FRAC_BITS-1:0] w_frac;
    logic [RW-1:0]        w_rem0;

    assign w_m0_sh = r_m0 >>> FRAC_BITS;
    assign w_m1_sh = r_m1 >>> FRAC_BITS;
    assign w_n0_sh = r_n0 >>> FRAC_BITS;
    assign w_m0_x  = {{2{r_m0[15]}}, r_m0};
    assign w_m1_x  = {{2{r_m1[15]}}, r_m1};
    assign w_m1_c  = {{2{w_m1_sh[15]}}, w_m1_sh};
    assign w_frac  = r_n0[FRAC_BITS-1:0];
    assign w_rem0  = RW'(w_frac) * RW'(r_dmaj);

    // Column step: the minor coordinate at the column's far border.
    logic signed [17:0]   w_knext, w_kend, w_ce, w_dce;
    logic [FRAC_BITS:0]   w_delta;
    logic signed [RW-1:0] w_dmin_x, w_delta_x, w_prod, w_den, w_sum;

    assign w_knext   = r_k + 18'sd1;
    assign w_kend    = w_knext <<< FRAC_BITS;
    assign w_ce      = (w_kend < w_m1_x) ? w_kend : w_m1_x;
    assign w_dce     = w_ce - r_cs;
    assign w_delta   = w_dce[FRAC_BITS:0];
    assign w_dmin_x  = RW'(r_dmin);
    assign w_delta_x = $signed(RW'(w_delta));
    assign w_prod    = w_dmin_x * w_delta_x;
    assign w_den     = $signed(RW'(r_dmaj) << FRAC_BITS);
    assign w_sum     = r_rem + r_prod;

    // Minor span of one column.
    logic signed [17:0] w_lo, w_hi, w_lo_c, w_hi_c;
    logic               w_col_skip;

    assign w_lo       = (r_qs < r_q) ? r_qs : r_q;
    assign w_hi       = (r_qs < r_q) ? r_q : r_qs;
    assign w_lo_c     = (w_lo < 18'sd0) ? 18'sd0 : w_lo;
    assign w_hi_c     = (w_hi > LastCell) ? LastCell : w_hi;
    assign w_col_skip = (r_k < 18'sd0) || (w_hi < 18'sd0) || (w_lo > LastCell);

    // Model square.
    logic signed [17:0] w_xa_x, w_ya_x, w_rad_x;
    logic signed [17:0] w_xlo, w_xhi, w_ylo, w_yhi;
    logic signed [17:0] w_mx0, w_mx1, w_my0, w_my1;
    logic               w_model_empty;

    assign w_xa_x  = {{2{r_xa[15]}}, r_xa};
    assign w_ya_x  = {{2{r_ya[15]}}, r_ya};
    assign w_rad_x = {3'b000, r_rad};
    assign w_xlo   = (w_xa_x - w_rad_x) >>> FRAC_BITS;
    assign w_xhi   = (w_xa_x + w_rad_x) >>> FRAC_BITS;
    assign w_ylo   = (w_ya_x - w_rad_x) >>> FRAC_BITS;
    assign w_yhi   = (w_ya_x + w_rad_x) >>> FRAC_BITS;
    assign w_mx0   = (w_xlo < 18'sd0) ? 18'sd0 : w_xlo;
    assign w_mx1   = (w_xhi > LastCell) ? LastCell : w_xhi;
    assign w_my0   = (w_ylo < 18'sd0) ? 18'sd0 : w_ylo;
    assign w_my1   = (w_yhi > LastCell) ? LastCell : w_yhi;
    assign w_model_empty = (w_mx0 > w_mx1) || (w_my0 > w_my1);

    // Cell of the next push.
    logic          w_is_wall;
    logic [MW-1:0] w_kcell, w_px, w_py;
    logic [CW-1:0] w_cell;

    assign w_is_wall = (r_op == gsbi_pkg::OP_ADD_WALL);
    assign w_kcell   = r_k[MW-1:0];
    assign w_px      = w_is_wall ? (r_xmaj ? w_kcell : r_j) : r_cx;
    assign w_py      = w_is_wall ? (r_xmaj ? r_j : w_kcell) : r_cy;
    assign w_cell    = CW'(w_px) + CW'(w_py) * CW'(MAP_SIZE);

    logic w_head_oob, w_slot_oob;
    assign w_head_oob = (17'(r_rcell) >= 17'(CELL_COUNT));
    assign w_slot_oob = (17'(r_rslot) >= 17'(POOL_DEPTH));

    always_comb begin
        w_req.valid = (r_state == T_PUSH) || (r_state == T_RD_REQ);
        if (r_state == T_PUSH) begin
            w_req.kind = gsbi_pkg::KIND_PUSH;
        end else if (r_op == gsbi_pkg::OP_READ_HEAD) begin
            w_req.kind = gsbi_pkg::KIND_HEAD;
        end else begin
            w_req.kind = gsbi_pkg::KIND_POOL;
        end
        w_req.cell_num = (r_state == T_PUSH) ? 16'(w_cell) : {4'b0000, r_rcell};
        w_req.slot     = {2'b00, r_rslot};
        w_req.typ      = (r_op == gsbi_pkg::OP_ADD_MODEL);
        w_req.obj      = r_obj;
    end

    logic w_in_accept, w_out_free;
    assign o_stall     = (r_state != T_IDLE) || !w_st_ready;
    assign w_in_accept = i_valid && !o_stall;
    assign w_out_free  = !r_o_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= T_IDLE;
        end else begin
            unique case (r_state)
                T_IDLE: begin
                    if (w_in_accept) begin
                        r_state <= T_SETUP;
                    end
                end
                T_SETUP: begin
                    unique case (r_op)
                        gsbi_pkg::OP_ADD_WALL:
                            r_state <= w_degen ? T_FIN : T_W_INIT;
                        gsbi_pkg::OP_ADD_MODEL:
                            r_state <= (r_route || w_model_empty) ? T_FIN : T_PUSH;
                        gsbi_pkg::OP_READ_HEAD:
                            r_state <= w_head_oob ? T_FIN : T_RD_REQ;
                        gsbi_pkg::OP_READ_POOL:
                            r_state <= w_slot_oob ? T_FIN : T_RD_REQ;
                        default: r_state <= T_FIN;
                    endcase
                end
                T_W_INIT: r_state <= T_W_COL;
                T_W_COL:  r_state <= (r_k > r_e) ? T_FIN : T_W_ADV;
                T_W_ADV:  r_state <= T_W_SPAN;
                T_W_SPAN: r_state <= w_col_skip ? T_W_COL : T_PUSH;
                T_PUSH: begin
                    if (w_st_ready) begin
                        r_state <= T_WAIT;
                    end
                end
                T_WAIT: begin
                    if (w_rsp.done) begin
                        if (w_is_wall) begin
                            r_state <= (r_j == r_jhi) ? T_W_COL : T_PUSH;
                        end else if (r_cx == r_x1 && r_cy == r_y1) begin
                            r_state <= T_FIN;
                        end else begin
                            r_state <= T_PUSH;
                        end
                    end
                end
                T_RD_REQ: begin
                    if (w_st_ready) begin
                        r_state <= T_RD_WAIT;
                    end
                end
                T_RD_WAIT: begin
                    if (w_rsp.done) begin
                        r_state <= T_FIN;
                    end
                end
                T_FIN: begin
                    if (w_out_free) begin
                        r_state <= T_IDLE;
                    end
                end
                default: r_state <= T_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == T_IDLE && w_in_accept) begin
            r_op    <= i_opcode;
            r_obj   <= i_object_index;
            r_xa    <= i_x_a;
            r_ya    <= i_y_a;
            r_xb    <= i_x_b;
            r_yb    <= i_y_b;
            r_rad   <= i_radius;
            r_route <= i_dynamic_flag || !i_description_valid || i_breakable;
            r_rcell <= i_read_cell;
            r_rslot <= i_read_slot;
        end

        unique case (r_state)
            T_SETUP: begin
                r_added <= '0;
                r_ovf   <= 1'b0;
                r_dyn   <= (r_op == gsbi_pkg::OP_ADD_MODEL) && r_route;
                r_degen <= w_is_wall && w_degen;
                r_link  <= gsbi_pkg::EMPTY_LINK;
                r_rtype <= 1'b0;
                r_robj  <= 16'd0;
                r_xmaj  <= w_xmaj;
                // Orient the wall so the major coordinate grows.
                if (w_xmaj) begin
                    r_m0   <= w_fwd ? r_xa : r_xb;
                    r_n0   <= w_fwd ? r_ya : r_yb;
                    r_m1   <= w_fwd ? r_xb : r_xa;
                    r_dmaj <= w_adx;
                    r_dmin <= w_fwd ? w_dy : -w_dy;
                end else begin
                    r_m0   <= w_fwd ? r_ya : r_yb;
                    r_n0   <= w_fwd ? r_xa : r_xb;
                    r_m1   <= w_fwd ? r_yb : r_ya;
                    r_dmaj <= w_ady;
                    r_dmin <= w_fwd ? w_dx : -w_dx;
                end
                r_x0 <= w_mx0[MW-1:0];
                r_x1 <= w_mx1[MW-1:0];
                r_y1 <= w_my1[MW-1:0];
                r_cx <= w_mx0[MW-1:0];
                r_cy <= w_my0[MW-1:0];
            end
            T_W_INIT: begin
                // At the start point the minor value is n0 / one exactly.
                r_k   <= {{2{w_m0_sh[15]}}, w_m0_sh};
                r_e   <= (w_m1_c > LastCell) ? LastCell : w_m1_c;
                r_q   <= {{2{w_n0_sh[15]}}, w_n0_sh};
                r_rem <= $signed(w_rem0);
                r_cs  <= w_m0_x;
            end
            T_W_COL: begin
                r_prod <= w_prod;
                r_cs   <= w_ce;
            end
            T_W_ADV: begin
                // The slope is at most one, so the floor moves by at most one per column.
                r_qs <= r_q;
                if (w_sum >= w_den) begin
                    r_rem <= w_sum - w_den;
                    r_q   <= r_q + 18'sd1;
                end else if (w_sum < $signed(RW'(0))) begin
                    r_rem <= w_sum + w_den;
                    r_q   <= r_q - 18'sd1;
                end else begin
                    r_rem <= w_sum;
                end
            end
            T_W_SPAN: begin
                if (w_col_skip) begin
                    r_k <= w_knext;
                end else begin
                    r_j   <= w_lo_c[MW-1:0];
                    r_jhi <= w_hi_c[MW-1:0];
                end
            end
            T_WAIT: begin
                if (w_rsp.done) begin
                    if (w_rsp.pushed) begin
                        r_added <= r_added + 17'd1;
                    end
                    if (w_rsp.overflow) begin
                        r_ovf <= 1'b1;
                    end
                    if (w_is_wall) begin
                        if (r_j == r_jhi) begin
                            r_k <= w_knext;
                        end else begin
                            r_j <= r_j + 1'b1;
                        end
                    end else if (r_cx == r_x1) begin
                        r_cx <= r_x0;
                        r_cy <= r_cy + 1'b1;
                    end else begin
                        r_cx <= r_cx + 1'b1;
                    end
                end
            end
            T_RD_WAIT: begin
                if (w_rsp.done) begin
                    r_link  <= w_rsp.link;
                    r_rtype <= w_rsp.typ;
                    r_robj  <= w_rsp.obj;
                end
            end
            default: ;
        endcase
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (r_state == T_FIN && w_out_free) begin
            r_o_valid <= 1'b1;
        end else if (!i_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == T_FIN && w_out_free) begin
            r_o_added <= (r_added > 17'd8191) ? 13'h1FFF : r_added[12:0];
            r_o_used  <= (17'(w_pool_count) > 17'd32767) ? 15'h7FFF : 15'(w_pool_count);
            r_o_dyn   <= r_dyn;
            r_o_degen <= r_degen;
            r_o_ovf   <= r_ovf;
            r_o_link  <= r_link;
            r_o_rtype <= r_rtype;
            r_o_robj  <= r_robj;
        end
    end

    assign o_valid              = r_o_valid;
    assign o_cells_added        = r_o_added;
    assign o_pool_used          = r_o_used;
    assign o_to_dynamic_list    = r_o_dyn;
    assign o_skipped_degenerate = r_o_degen;
    assign o_overflow           = r_o_ovf;
    assign o_read_link          = r_o_link;
    assign o_read_type          = r_o_rtype;
    assign o_read_object        = r_o_robj;

endmodule
